@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

@@ rtl/acbr_pkg.sv @@
// ----------------------------------------------------------------------------
// acbr_pkg
// shared types, constants and helpers of the circle blend rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package acbr_pkg;

    localparam int SIZE_W      = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QLEVEL_W    = 2;

    // q.8 half pixel and the 1.496 pixel box bias
    localparam logic [7:0]  HALF_PIX      = 8'd128;
    localparam logic [8:0]  BOX_HIGH_BIAS = 9'd383;
    localparam logic [7:0]  CH_MAX        = 8'd255;

    typedef enum logic [1:0] {
        REQ_FILL   = 2'd0,
        REQ_CIRCLE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        req_t        op;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] radius;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  read_col;
        logic [7:0]  read_row;
    } cmd_t;

    typedef struct packed {
        logic [QLEVEL_W-1:0] level;
        logic                empty;
        logic                full;
    } queue_status_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } engine_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_SCALE,
        ST_BOX,
        ST_PIX_SQ,
        ST_PIX_SUM,
        ST_PIX_ROOT,
        ST_PIX_COV,
        ST_PIX_MUL,
        ST_PIX_WRITE,
        ST_DONE
    } state_t;

    // floor(x / 255) for x up to 255*255, reciprocal plus one correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [23:0] p;
        logic [7:0]  q0;
        logic [16:0] rem;
        p   = {x, 8'b0} + 24'(x);
        q0  = p[23:16];
        rem = 17'(x) - (17'({q0, 8'b0}) - 17'(q0));
        return (rem >= 17'(CH_MAX)) ? q0 + 8'd1 : q0;
    endfunction

    // (v * c + 128) >> 8
    function automatic logic [7:0] cov_scale(input logic [7:0] v, input logic [7:0] c);
        logic [15:0] s;
        s = 16'(v) * 16'(c) + 16'(HALF_PIX);
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/acbr_front.sv @@
// ----------------------------------------------------------------------------
// acbr_front
// accepts request words, decodes them and queues them for the engine
// ----------------------------------------------------------------------------
`default_nettype none

module acbr_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [95:0]            s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire acbr_pkg::engine_status_t eng_stat,
    output acbr_pkg::cmd_t              head,
    output acbr_pkg::queue_status_t     q_stat
);

    acbr_pkg::cmd_t                      entry_reg [acbr_pkg::QUEUE_DEPTH];
    logic [acbr_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [acbr_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [acbr_pkg::QLEVEL_W-1:0]       level_reg;
    logic [acbr_pkg::QLEVEL_W-1:0]       level_next;
    acbr_pkg::cmd_t                      cmd_in;
    logic                                push;
    logic                                full;

    always_comb begin
        cmd_in.op       = acbr_pkg::req_t'(s_tuser);
        cmd_in.center_x = s_tdata[15:0];
        cmd_in.center_y = s_tdata[31:16];
        cmd_in.radius   = s_tdata[47:32];
        cmd_in.red      = s_tdata[55:48];
        cmd_in.green    = s_tdata[63:56];
        cmd_in.blue     = s_tdata[71:64];
        cmd_in.alpha    = s_tdata[79:72];
        cmd_in.read_col = s_tdata[87:80];
        cmd_in.read_row = s_tdata[95:88];
    end

    assign full     = (level_reg == acbr_pkg::QLEVEL_W'(acbr_pkg::QUEUE_DEPTH));
    assign s_tready = !full && !eng_stat.clearing;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        level_next = level_reg;
        if (push && !eng_stat.pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push && eng_stat.pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (eng_stat.pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.level = level_reg;
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.full  = full;

endmodule

`default_nettype wire

@@ rtl/acbr_isqrt.sv @@
// ----------------------------------------------------------------------------
// acbr_isqrt
// floor square root of a 36 bit value, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module acbr_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [35:0] radicand,
    output logic             done,
    output logic [17:0]      root
);

    logic [35:0] rad_reg;
    logic [21:0] rem_reg;
    logic [17:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [21:0] rem_sh;
    logic [21:0] trial;
    logic        take;

    assign rem_sh = {rem_reg[19:0], rad_reg[35:34]};
    assign trial  = {2'b0, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd17) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[33:0], 2'b00};
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[16:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ rtl/acbr_engine.sv @@
// ----------------------------------------------------------------------------
// acbr_engine
// runs queued requests against the frame store and returns one word each
// ----------------------------------------------------------------------------
`default_nettype none

module acbr_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [8:0]              frame_width,
    input  wire logic [8:0]              frame_height,
    input  wire acbr_pkg::queue_status_t q_stat,
    input  wire acbr_pkg::cmd_t          head,
    output acbr_pkg::engine_status_t     eng_stat,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [23:0]                  m_tdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    acbr_pkg::state_t state_reg;
    acbr_pkg::state_t state_next;

    logic [23:0]   mem [DEPTH];
    logic [23:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] clr_addr_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [23:0]   mem_wd;

    acbr_pkg::cmd_t cmd_reg;
    logic [16:0] cx_reg, cy_reg, rad_reg;
    logic [9:0]  left_reg;
    logic [8:0]  right_reg, bottom_reg;
    logic [8:0]  col_reg, row_reg;
    logic [33:0] dxsq_reg, dysq_reg;
    logic [7:0]  va_reg, vr_reg, vg_reg, vb_reg;
    logic [15:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic [23:0] result_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    logic        pop, sq_start, load_out;
    logic        sq_done;
    logic [17:0] sq_root;

    logic [24:0] cx_prod, cy_prod, r_prod;
    logic signed [18:0] lo_x, lo_y;
    logic [18:0] hi_x, hi_y;
    logic [9:0]  left_x, top_y;
    logic [8:0]  right_x, bottom_y;
    logic [8:0]  w_last, h_last;
    logic        box_empty;
    logic signed [18:0] dx, dy;
    logic signed [37:0] dx_sq, dy_sq;
    logic [17:0] r_plus;
    logic        in_circle, edge_band;
    logic [7:0]  cov;
    logic        last_col, last_row, last_pix;
    logic        fill_last;
    logic        in_frame;
    logic [23:0] blended;

    assign w_last = frame_width - 9'd1;
    assign h_last = frame_height - 9'd1;

    // ---- address and geometry ----
    assign pix_addr = AW'(32'(row_reg) * 32'(MAX_WIDTH) + 32'(col_reg));
    assign rd_addr  = (state_reg == acbr_pkg::ST_READ_ADDR)
                    ? AW'(32'(cmd_reg.read_row) * 32'(MAX_WIDTH) + 32'(cmd_reg.read_col))
                    : pix_addr;
    assign in_frame = ({1'b0, cmd_reg.read_col} < frame_width) &&
                      ({1'b0, cmd_reg.read_row} < frame_height);

    assign cx_prod = 25'(cmd_reg.center_x) * 25'(frame_width);
    assign cy_prod = 25'(cmd_reg.center_y) * 25'(frame_height);
    assign r_prod  = 25'(cmd_reg.radius) * 25'(frame_width);

    assign lo_x = $signed({2'b0, cx_reg}) - $signed({2'b0, rad_reg}) - 19'sd128;
    assign lo_y = $signed({2'b0, cy_reg}) - $signed({2'b0, rad_reg}) - 19'sd128;
    assign hi_x = {2'b0, cx_reg} + {2'b0, rad_reg} + 19'(acbr_pkg::BOX_HIGH_BIAS);
    assign hi_y = {2'b0, cy_reg} + {2'b0, rad_reg} + 19'(acbr_pkg::BOX_HIGH_BIAS);
    assign left_x   = lo_x[18] ? 10'd0 : {1'b0, lo_x[16:8]};
    assign top_y    = lo_y[18] ? 10'd0 : {1'b0, lo_y[16:8]};
    assign right_x  = (hi_x[17:8] > {1'b0, w_last}) ? w_last : hi_x[16:8];
    assign bottom_y = (hi_y[17:8] > {1'b0, h_last}) ? h_last : hi_y[16:8];
    assign box_empty = (left_x > {1'b0, right_x}) || (top_y > {1'b0, bottom_y});

    assign dx    = $signed({2'b0, col_reg, 8'b0}) - $signed({2'b0, cx_reg});
    assign dy    = $signed({2'b0, row_reg, 8'b0}) - $signed({2'b0, cy_reg});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    assign r_plus    = {1'b0, rad_reg} + 18'(acbr_pkg::HALF_PIX);
    assign in_circle = (sq_root < r_plus);
    assign edge_band = ({1'b0, sq_root} + 19'(acbr_pkg::HALF_PIX)) > {2'b0, rad_reg};
    assign cov       = 8'(r_plus - sq_root);

    assign last_col  = (col_reg == right_reg);
    assign last_row  = (row_reg == bottom_reg);
    assign last_pix  = last_col && last_row;
    assign fill_last = (col_reg == w_last) && (row_reg == h_last);

    function automatic logic [7:0] blend_ch(input logic [15:0] p, input logic [7:0] v);
        logic [8:0] n;
        n = {1'b0, acbr_pkg::div255(p)} + {1'b0, v};
        return n[8] ? acbr_pkg::CH_MAX : n[7:0];
    endfunction

    assign blended = {blend_ch(prod_r_reg, vr_reg), blend_ch(prod_g_reg, vg_reg),
                      blend_ch(prod_b_reg, vb_reg)};

    acbr_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({1'b0, {1'b0, dxsq_reg} + {1'b0, dysq_reg}}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            acbr_pkg::ST_CLEAR: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) state_next = acbr_pkg::ST_IDLE;
            end
            acbr_pkg::ST_IDLE: begin
                if (!q_stat.empty) begin
                    case (head.op)
                        acbr_pkg::REQ_FILL:   state_next = acbr_pkg::ST_FILL;
                        acbr_pkg::REQ_CIRCLE: state_next = acbr_pkg::ST_SCALE;
                        acbr_pkg::REQ_READ:   state_next = acbr_pkg::ST_READ_ADDR;
                        default:              state_next = acbr_pkg::ST_DONE;
                    endcase
                end
            end
            acbr_pkg::ST_FILL: begin
                if (fill_last) state_next = acbr_pkg::ST_DONE;
            end
            acbr_pkg::ST_READ_ADDR: state_next = acbr_pkg::ST_READ_DATA;
            acbr_pkg::ST_READ_DATA: state_next = acbr_pkg::ST_DONE;
            acbr_pkg::ST_SCALE:     state_next = acbr_pkg::ST_BOX;
            acbr_pkg::ST_BOX: begin
                state_next = box_empty ? acbr_pkg::ST_DONE : acbr_pkg::ST_PIX_SQ;
            end
            acbr_pkg::ST_PIX_SQ:  state_next = acbr_pkg::ST_PIX_SUM;
            acbr_pkg::ST_PIX_SUM: state_next = acbr_pkg::ST_PIX_ROOT;
            acbr_pkg::ST_PIX_ROOT: begin
                if (sq_done) state_next = acbr_pkg::ST_PIX_COV;
            end
            acbr_pkg::ST_PIX_COV: begin
                if (in_circle)     state_next = acbr_pkg::ST_PIX_MUL;
                else if (last_pix) state_next = acbr_pkg::ST_DONE;
                else               state_next = acbr_pkg::ST_PIX_SQ;
            end
            acbr_pkg::ST_PIX_MUL: state_next = acbr_pkg::ST_PIX_WRITE;
            acbr_pkg::ST_PIX_WRITE: begin
                state_next = last_pix ? acbr_pkg::ST_DONE : acbr_pkg::ST_PIX_SQ;
            end
            acbr_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = acbr_pkg::ST_IDLE;
            end
            default: state_next = acbr_pkg::ST_IDLE;
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = pix_addr;
        mem_wd   = blended;
        pop      = 1'b0;
        sq_start = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            acbr_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = '0;
            end
            acbr_pkg::ST_IDLE:  pop = !q_stat.empty;
            acbr_pkg::ST_FILL: begin
                mem_we = 1'b1;
                mem_wd = {cmd_reg.red, cmd_reg.green, cmd_reg.blue};
            end
            acbr_pkg::ST_PIX_SUM:   sq_start = 1'b1;
            acbr_pkg::ST_PIX_WRITE: mem_we = 1'b1;
            acbr_pkg::ST_DONE:      load_out = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // ---- frame store ----
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ---- control ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= acbr_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == acbr_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath ----
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {result_reg[7:0], result_reg[15:8], result_reg[23:16]};
        end
        case (state_reg)
            acbr_pkg::ST_IDLE: begin
                cmd_reg    <= head;
                result_reg <= '0;
                col_reg    <= '0;
                row_reg    <= '0;
            end
            acbr_pkg::ST_FILL: begin
                if (col_reg == w_last) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 9'd1;
                end else begin
                    col_reg <= col_reg + 9'd1;
                end
            end
            acbr_pkg::ST_READ_DATA: begin
                result_reg <= in_frame ? rd_data_reg : '0;
            end
            acbr_pkg::ST_SCALE: begin
                cx_reg  <= cx_prod[24:8];
                cy_reg  <= cy_prod[24:8];
                rad_reg <= r_prod[24:8];
            end
            acbr_pkg::ST_BOX: begin
                left_reg   <= left_x;
                right_reg  <= right_x;
                bottom_reg <= bottom_y;
                col_reg    <= left_x[8:0];
                row_reg    <= top_y[8:0];
            end
            acbr_pkg::ST_PIX_SQ: begin
                dxsq_reg <= dx_sq[33:0];
                dysq_reg <= dy_sq[33:0];
            end
            acbr_pkg::ST_PIX_COV: begin
                // edge band scales colour and opacity by the coverage
                va_reg <= edge_band ? acbr_pkg::cov_scale(cmd_reg.alpha, cov) : cmd_reg.alpha;
                vr_reg <= edge_band ? acbr_pkg::cov_scale(cmd_reg.red, cov)   : cmd_reg.red;
                vg_reg <= edge_band ? acbr_pkg::cov_scale(cmd_reg.green, cov) : cmd_reg.green;
                vb_reg <= edge_band ? acbr_pkg::cov_scale(cmd_reg.blue, cov)  : cmd_reg.blue;
                if (!in_circle) begin
                    if (last_col) begin
                        col_reg <= left_reg[8:0];
                        row_reg <= row_reg + 9'd1;
                    end else begin
                        col_reg <= col_reg + 9'd1;
                    end
                end
            end
            acbr_pkg::ST_PIX_MUL: begin
                prod_r_reg <= 16'(rd_data_reg[23:16]) * 16'(acbr_pkg::CH_MAX - va_reg);
                prod_g_reg <= 16'(rd_data_reg[15:8])  * 16'(acbr_pkg::CH_MAX - va_reg);
                prod_b_reg <= 16'(rd_data_reg[7:0])   * 16'(acbr_pkg::CH_MAX - va_reg);
            end
            acbr_pkg::ST_PIX_WRITE: begin
                if (last_col) begin
                    col_reg <= left_reg[8:0];
                    row_reg <= row_reg + 9'd1;
                end else begin
                    col_reg <= col_reg + 9'd1;
                end
            end
            default: ;
        endcase
    end

    assign eng_stat.clearing = (state_reg == acbr_pkg::ST_CLEAR);
    assign eng_stat.pop      = pop;
    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;

endmodule

`default_nettype wire

@@ rtl/antialiased_circle_blend_raster.sv @@
// ----------------------------------------------------------------------------
// antialiased_circle_blend_raster
// the engine runs one request at a time; the frame store port and the bit serial
// square root (18 steps per pixel) set the circle pixel rate
// reset: synchronous, store cleared one word a cycle over all MAX_WIDTH*MAX_HEIGHT
// words, no request accepted until the sweep ends
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module antialiased_circle_blend_raster #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // center_x, center_y, circle_radius, paint_red, paint_green, paint_blue,
    // paint_alpha, read_col, read_row
    input  wire logic [95:0] s_tdata,
    // req_type
    input  wire logic [1:0]  s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_red, pixel_green, pixel_blue
    output logic [23:0]      m_tdata,
    // register write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [8:0]  cfg_wdata
);

    // reset sizes, held to the store dimensions
    localparam logic [8:0] W_RST = (MAX_WIDTH < 256)  ? 9'(MAX_WIDTH)  : 9'd256;
    localparam logic [8:0] H_RST = (MAX_HEIGHT < 256) ? 9'(MAX_HEIGHT) : 9'd256;

    logic [8:0] frame_width_reg;
    logic [8:0] frame_height_reg;
    logic [8:0] w_clamped;
    logic [8:0] h_clamped;

    acbr_pkg::queue_status_t  q_stat;
    acbr_pkg::engine_status_t eng_stat;
    acbr_pkg::cmd_t           head;

    // zero acts as one, anything past the store acts as its edge
    assign w_clamped = (cfg_wdata == 9'd0) ? 9'd1
                     : (32'(cfg_wdata) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg_wdata;
    assign h_clamped = (cfg_wdata == 9'd0) ? 9'd1
                     : (32'(cfg_wdata) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= W_RST;
            frame_height_reg <= H_RST;
        end else if (cfg_we) begin
            case (acbr_pkg::cfg_reg_t'(cfg_addr))
                acbr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= w_clamped;
                acbr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= h_clamped;
                default: ;
            endcase
        end
    end

    // front: takes words and holds them in a two entry queue
    acbr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .eng_stat (eng_stat),
        .head     (head),
        .q_stat   (q_stat)
    );

    // back: store sweep, fill, circle walk and read, with the output register
    acbr_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_stat       (q_stat),
        .head         (head),
        .eng_stat     (eng_stat),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    // no word taken while the store is still being cleared
    `ASSERT_NEVER(a_no_accept_in_clear, aclk, aresetn, s_tvalid && s_tready && eng_stat.clearing, "word accepted during clear")
    // queue level stays within its depth
    `ASSERT_NEVER(a_queue_bound, aclk, aresetn, q_stat.level > acbr_pkg::QLEVEL_W'(acbr_pkg::QUEUE_DEPTH), "queue overflow")
    // engine only takes a request that is there
    `ASSERT_NEVER(a_pop_nonempty, aclk, aresetn, eng_stat.pop && q_stat.empty, "pop from empty queue")
    // a pop with no push lowers the level by one
    `ASSERT_AT(a_pop_level, aclk, aresetn, (eng_stat.pop && !(s_tvalid && s_tready)) |=> (q_stat.level == $past(q_stat.level) - 1'b1), "queue level mismatch")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the antialiased circle blend rasterizer: a short
// table of directed requests, then random fills, circles, reads and no-op
// requests over a series of frame sizes, each result checked against a table
// value or an in-bench model of the frame store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int MAXW      = 256;
    localparam int MAXH      = 256;
    localparam int IDLE_LIMIT = 400000;   // reset sweep and one full fill fit well inside
    localparam int HOLD_LEN  = 3000;      // long receiver hold-off

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = acbr_pkg::REQ_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = acbr_pkg::REG_FRAME_WIDTH;
    logic [8:0]  cfg_wdata = '0;

    antialiased_circle_blend_raster #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one request word
    typedef struct {
        acbr_pkg::req_t op;
        logic [15:0] cx, cy, rad;
        logic [7:0]  red, green, blue, alpha;
        logic [7:0]  col, row;
        bit          typed;        // expected pixel given in the table
        logic [23:0] pix;          // {blue, green, red}
    } req_word_t;

    // model of the frame store and the size registers
    logic [23:0] pixel_mem [MAXW*MAXH];
    int unsigned cur_w = MAXW, cur_h = MAXH;
    logic [23:0] pixel_fifo [$];   // expected read-back pixels, oldest first

    int errors = 0;
    int words_in = 0, words_out = 0;
    int n_fill = 0, n_circle = 0, n_read = 0, n_phases = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0, bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] mix_chan(int unsigned old, int unsigned a, int unsigned v);
        int unsigned n;
        n = old * (255 - a) / 255 + v;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // blend one circle into the model store
    task automatic paint_circle(req_word_t w);
        longint cx, cy, r, x0, x1, y0, y1, dx, dy, d, cv, v;
        int unsigned vr, vg, vb, va;
        logic [23:0] old;
        cx = (longint'(w.cx) * cur_w) >>> 8;
        cy = (longint'(w.cy) * cur_h) >>> 8;
        r  = (longint'(w.rad) * cur_w) >>> 8;
        v = cx - r - 128; x0 = (v < 0) ? 0 : (v >>> 8);
        v = cy - r - 128; y0 = (v < 0) ? 0 : (v >>> 8);
        x1 = (cx + r + 383) >>> 8; if (x1 > cur_w - 1) x1 = cur_w - 1;
        y1 = (cy + r + 383) >>> 8; if (y1 > cur_h - 1) y1 = cur_h - 1;
        for (longint y = y0; y <= y1; y++) begin
            for (longint x = x0; x <= x1; x++) begin
                dx = x * 256 - cx;
                dy = y * 256 - cy;
                d = longint'(int_sqrt(longint'(dx * dx + dy * dy)));
                if (d >= r + 128) continue;
                vr = w.red; vg = w.green; vb = w.blue; va = w.alpha;
                // half-pixel edge band: scale colour and alpha by coverage
                if (d > r - 128) begin
                    cv = r + 128 - d;
                    va = (va * cv + 128) >> 8;
                    vr = (vr * cv + 128) >> 8;
                    vg = (vg * cv + 128) >> 8;
                    vb = (vb * cv + 128) >> 8;
                end
                old = pixel_mem[y * MAXW + x];
                pixel_mem[y * MAXW + x] = {mix_chan(old[23:16], va, vb),
                                           mix_chan(old[15:8], va, vg),
                                           mix_chan(old[7:0], va, vr)};
            end
        end
    endtask

    // update the store model for one accepted request, return the pixel it yields
    task automatic apply_request(req_word_t w, output logic [23:0] pix);
        pix = '0;
        case (w.op)
            acbr_pkg::REQ_FILL: begin
                for (int y = 0; y < cur_h; y++)
                    for (int x = 0; x < cur_w; x++)
                        pixel_mem[y * MAXW + x] = {w.blue, w.green, w.red};
                n_fill++;
            end
            acbr_pkg::REQ_CIRCLE: begin
                paint_circle(w);
                n_circle++;
            end
            acbr_pkg::REQ_READ: begin
                if (w.col < cur_w && w.row < cur_h) pix = pixel_mem[w.row * MAXW + w.col];
                n_read++;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_word(req_word_t w);
        logic [23:0] pix;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= {w.row, w.col, w.alpha, w.blue, w.green, w.red, w.rad, w.cy, w.cx};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        apply_request(w, pix);
        pixel_fifo.push_back(w.typed ? w.pix : pix);
        words_in++;
    endtask

    // register writes happen only with nothing in flight
    task automatic set_frame(int unsigned wv, int unsigned hv);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait (pixel_fifo.size() == 0);
        repeat (30) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= acbr_pkg::REG_FRAME_WIDTH;
        cfg_wdata <= wv[8:0];
        @(posedge aclk);
        cfg_addr  <= acbr_pkg::REG_FRAME_HEIGHT;
        cfg_wdata <= hv[8:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_w = clamp_dim(wv & 9'h1FF, MAXW);
        cur_h = clamp_dim(hv & 9'h1FF, MAXH);
        n_phases++;
    endtask

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic req_word_t random_word();
        req_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w.op = (pick < 8) ? acbr_pkg::REQ_FILL : (pick < 50) ? acbr_pkg::REQ_CIRCLE :
               (pick < 95) ? acbr_pkg::REQ_READ : acbr_pkg::REQ_NONE;
        w.cx  = 16'($urandom_range(0, 16'hFFFF));
        w.cy  = 16'($urandom_range(0, 16'hFFFF));
        w.rad = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                            : 16'($urandom_range(0, 16'h4000));
        w.red = edge_byte(); w.green = edge_byte(); w.blue = edge_byte();
        w.alpha = edge_byte();
        // reads mostly land inside the frame in use
        if ($urandom_range(0, 3) != 0) begin
            w.col = 8'($urandom_range(0, cur_w - 1));
            w.row = 8'($urandom_range(0, cur_h - 1));
        end else begin
            w.col = 8'($urandom_range(0, 255));
            w.row = 8'($urandom_range(0, 255));
        end
        w.typed = 1'b0;
        w.pix = '0;
        return w;
    endfunction

    // directed rows, run at the reset size of 256 by 256
    req_word_t dir_tab [] = '{
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd0,   8'd0,   1'b1, 24'h000000},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd255, 8'd255, 1'b1, 24'h000000},
        '{acbr_pkg::REQ_NONE,   16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'd255, 8'd255, 1'b1, 24'h000000},
        // zero radius dot at the middle
        '{acbr_pkg::REQ_CIRCLE, 16'h8000, 16'h8000, 16'h0000, 8'hFF, 8'h80, 8'h10, 8'hFF,
          8'd0,   8'd0,   1'b0, 24'h0},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd128, 8'd128, 1'b0, 24'h0},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd127, 8'd128, 1'b0, 24'h0},
        // clipped at the top-left corner, fully transparent
        '{acbr_pkg::REQ_CIRCLE, 16'h0000, 16'h0000, 16'h0100, 8'hFF, 8'hFF, 8'hFF, 8'h00,
          8'd0,   8'd0,   1'b0, 24'h0},
        '{acbr_pkg::REQ_CIRCLE, 16'h0000, 16'h0000, 16'h0200, 8'hFF, 8'hFF, 8'hFF, 8'h00,
          8'd0,   8'd0,   1'b0, 24'h0},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd0,   8'd0,   1'b0, 24'h0},
        // clipped at the far corner, half alpha
        '{acbr_pkg::REQ_CIRCLE, 16'hFFFF, 16'hFFFF, 16'h0200, 8'h55, 8'hAA, 8'h33, 8'h80,
          8'd0,   8'd0,   1'b0, 24'h0},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd255, 8'd255, 1'b0, 24'h0},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd254, 8'd254, 1'b0, 24'h0},
        '{acbr_pkg::REQ_FILL,   16'h0000, 16'h0000, 16'h0000, 8'h12, 8'h34, 8'h56, 8'h00,
          8'd0,   8'd0,   1'b1, 24'h000000},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd200, 8'd10,  1'b1, 24'h563412},
        // opaque white over the fill saturates
        '{acbr_pkg::REQ_CIRCLE, 16'h4000, 16'h4000, 16'h0100, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'd0,   8'd0,   1'b0, 24'h0},
        '{acbr_pkg::REQ_READ,   16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
          8'd64,  8'd64,  1'b1, 24'hFFFFFF}
    };

    // frame sizes walked by the random part, written raw so clamping is hit
    int unsigned size_list [][2] = '{
        '{16, 16}, '{0, 0}, '{511, 1}, '{0, 511}, '{9, 13}, '{300, 3}, '{32, 8}, '{1, 1},
        '{256, 256}
    };

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) send_word(dir_tab[i]);

        foreach (size_list[p]) begin
            set_frame(size_list[p][0], size_list[p][1]);
            // the last, full size phase only reads, a full frame circle is too slow
            for (int k = 0; k < ((p == size_list.size() - 1) ? 6 : 10); k++) begin
                req_word_t w;
                w = random_word();
                if (p == size_list.size() - 1) w.op = acbr_pkg::REQ_READ;
                send_word(w);
            end
        end
        s_tvalid <= 1'b0;

        wait (pixel_fifo.size() == 0);
        repeat (50) @(posedge aclk);
        $display("covered %0d words over %0d frame sizes: %0d fills, %0d circles, %0d reads",
                 words_in, n_phases, n_fill, n_circle, n_read);
        $display("long receiver hold-off with the sender still offering was exercised");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern that switches mode at random intervals,
    // plus one long hold-off once results have started flowing
    // ------------------------------------------------------------------
    int rx_mode = 0, rx_seg = 0, hold_left = 0;
    bit held_once = 1'b0;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!held_once && words_out == 30) begin
            held_once <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else begin
            if (rx_seg == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_seg  <= $urandom_range(50, 400);
            end else begin
                rx_seg <= rx_seg - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;                          // no stalls
                1: m_tready <= ($urandom_range(0, 1) == 0);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result checker, field by field against the oldest expected word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            logic [23:0] want;
            if (pixel_fifo.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                errors++;
            end else begin
                want = pixel_fifo.pop_front();
                for (int f = 0; f < 3; f++) begin
                    if (m_tdata[f*8 +: 8] !== want[f*8 +: 8]) begin
                        $display("%0t: result word %0d %s mismatch, expected %h, got %h",
                                 $time, words_out, (f == 0) ? "red" : (f == 1) ? "green" : "blue",
                                 want[f*8 +: 8], m_tdata[f*8 +: 8]);
                        errors++;
                    end
                end
            end
            words_out++;
        end
    end

    // watchdog on cycles where neither side moves a word
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding", $time, pixel_fifo.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

@@ antialiased_circle_blend_raster.f @@
+incdir+rtl
rtl/acbr_pkg.sv
rtl/acbr_front.sv
rtl/acbr_isqrt.sv
rtl/acbr_engine.sv
rtl/antialiased_circle_blend_raster.sv
tb/tb_top.sv
